FILE: rtl/text_console_writer_unit_defines.svh
// Assertion macros shared by the console writer checker
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define TCWU_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("console writer check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define TCWU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("console writer check failed");

`endif

FILE: rtl/tcw_pkg.sv
// Package: field widths, codes and result type of the text console writer
`default_nettype none

package tcw_pkg;

	localparam int COLS_DEF = 80;
	localparam int ROWS_DEF = 25;

	localparam int OP_W   = 2;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int IDX_W  = 11;
	localparam int POS_W  = 11;
	localparam int LINE_W = 5;
	localparam int COL_W  = 7;
	localparam int CELL_W = CHAR_W + ATTR_W;

	localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;

	typedef struct packed {
		logic [POS_W-1:0]  cursor_pos;
		logic [LINE_W-1:0] cursor_line;
		logic [COL_W-1:0]  cursor_column;
		logic [CHAR_W-1:0] read_char;
		logic [ATTR_W-1:0] read_attr;
	} tcw_result_t;

endpackage

`default_nettype wire

FILE: rtl/tcw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data
`default_nettype none

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/tcw_outreg.sv
// Result register: holds one transaction until the consumer takes it
`default_nettype none

module tcw_outreg import tcw_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire tcw_result_t res_in,
	input  wire logic        out_stall,
	output logic             out_valid,
	output tcw_result_t      res_out,
	output logic             free
);

	logic valid_q;

	// free: empty now, or drained at this edge
	assign free      = !valid_q || !out_stall;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_out <= res_in;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/tcw_seq.sv
// Sequencer: cursor, item decode and read-modify-write sweeps over the cell RAM
`default_nettype none

module tcw_seq import tcw_pkg::*; #(
	parameter int COLS = COLS_DEF,
	parameter int ROWS = ROWS_DEF,
	localparam int CELLS = ROWS * COLS,
	localparam int AW = $clog2(CELLS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [OP_W-1:0]   operation,
	input  wire logic [CHAR_W-1:0] char_code,
	input  wire logic [ATTR_W-1:0] attr,
	input  wire logic [IDX_W-1:0]  cell_index,
	input  wire logic              out_free,
	output logic                   load,
	output tcw_result_t            res,
	output logic                   mem_we,
	output logic [AW-1:0]          mem_waddr,
	output logic [CELL_W-1:0]      mem_wdata,
	output logic                   mem_re,
	output logic [AW-1:0]          mem_raddr,
	input  wire logic [CELL_W-1:0] mem_rdata
);

	localparam int LW = $clog2(ROWS);
	localparam int CW = $clog2(COLS + 1);

	localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
	localparam logic [AW-1:0] ROW1_START = AW'(COLS);
	localparam logic [AW-1:0] BOTTOM_ROW = AW'((ROWS - 1) * COLS);
	localparam logic [LW-1:0] BOT_LINE   = LW'(ROWS - 1);
	localparam logic [CW-1:0] COL_WRAP   = CW'(COLS);

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_EXEC  = 3'd2;
	localparam logic [2:0] ST_RDW   = 3'd3;
	localparam logic [2:0] ST_COPY  = 3'd4;
	localparam logic [2:0] ST_BLANK = 3'd5;
	localparam logic [2:0] ST_PUTW  = 3'd6;

	logic [2:0]        state_q, state_d;
	logic [AW-1:0]     sweep_q, sweep_d;
	logic [LW-1:0]     line_q, line_d;
	logic [CW-1:0]     col_q, col_d;
	logic              cp_pend_s1, cp_pend_d;
	logic [AW-1:0]     cp_addr_s1, cp_addr_d;
	logic [OP_W-1:0]   op_q;
	logic [CHAR_W-1:0] ch_q;
	logic [ATTR_W-1:0] attr_q;
	logic [IDX_W-1:0]  idx_q;

	logic              accept;
	logic              rd_hit;
	logic              line_last;
	logic              idx_ok;
	logic [AW-1:0]     row_base;
	logic [CELL_W-1:0] blank_cell;
	logic [CELL_W-1:0] char_cell;
	logic [31:0]       pos_full;

	assign in_stall   = (state_q != ST_IDLE);
	assign accept     = in_valid && !in_stall;
	assign line_last  = (line_q == BOT_LINE);
	assign idx_ok     = (32'(idx_q) < 32'(CELLS));
	assign row_base   = AW'(32'(line_q) * 32'(COLS));
	assign blank_cell = {attr_q, CH_BLANK};
	assign char_cell  = {attr_q, ch_q};

	always_comb begin
		state_d   = state_q;
		sweep_d   = sweep_q;
		line_d    = line_q;
		col_d     = col_q;
		cp_pend_d = 1'b0;
		cp_addr_d = cp_addr_s1;
		mem_we    = 1'b0;
		mem_waddr = sweep_q;
		mem_wdata = blank_cell;
		mem_re    = 1'b0;
		mem_raddr = AW'(idx_q);
		load      = 1'b0;
		rd_hit    = 1'b0;

		case (state_q)
			ST_INIT: begin
				// reset pass: whole store to space with attribute zero
				mem_we    = 1'b1;
				mem_wdata = {ATTR_W'(0), CH_BLANK};
				if (sweep_q == LAST_CELL) begin
					state_d = ST_IDLE;
				end else begin
					sweep_d = sweep_q + AW'(1);
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					case (op_q)
						OP_PUT: begin
							if (ch_q == CH_NEWLINE) begin
								col_d = '0;
								if (line_last) begin
									sweep_d = ROW1_START;
									state_d = ST_COPY;
								end else begin
									line_d  = line_q + LW'(1);
									load    = 1'b1;
									state_d = ST_IDLE;
								end
							end else if (ch_q == CH_BACKSPACE) begin
								if (col_q != '0) begin
									col_d     = col_q - CW'(1);
									mem_we    = 1'b1;
									mem_waddr = row_base + AW'(col_q) - AW'(1);
								end
								load    = 1'b1;
								state_d = ST_IDLE;
							end else if (col_q == COL_WRAP) begin
								col_d = '0;
								if (line_last) begin
									sweep_d = ROW1_START;
									state_d = ST_COPY;
								end else begin
									line_d    = line_q + LW'(1);
									col_d     = CW'(1);
									mem_we    = 1'b1;
									mem_waddr = row_base + AW'(COLS);
									mem_wdata = char_cell;
									load      = 1'b1;
									state_d   = ST_IDLE;
								end
							end else begin
								col_d     = col_q + CW'(1);
								mem_we    = 1'b1;
								mem_waddr = row_base + AW'(col_q);
								mem_wdata = char_cell;
								load      = 1'b1;
								state_d   = ST_IDLE;
							end
						end
						OP_CLEAR: begin
							line_d  = LW'(1);
							col_d   = '0;
							sweep_d = ROW1_START;
							state_d = ST_BLANK;
						end
						OP_READ: begin
							if (idx_ok) begin
								mem_re  = 1'b1;
								state_d = ST_RDW;
							end else begin
								load    = 1'b1;
								state_d = ST_IDLE;
							end
						end
						default: begin
							load    = 1'b1;
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_RDW: begin
				rd_hit  = 1'b1;
				load    = 1'b1;
				state_d = ST_IDLE;
			end
			ST_COPY: begin
				// read one row ahead, write back in the next cycle
				if (cp_pend_s1) begin
					mem_we    = 1'b1;
					mem_waddr = cp_addr_s1;
					mem_wdata = mem_rdata;
				end
				if (sweep_q != BOTTOM_ROW) begin
					mem_re    = 1'b1;
					mem_raddr = sweep_q + AW'(COLS);
					cp_pend_d = 1'b1;
					cp_addr_d = sweep_q;
					sweep_d   = sweep_q + AW'(1);
				end else begin
					state_d = ST_BLANK;
				end
			end
			ST_BLANK: begin
				mem_we = 1'b1;
				if (sweep_q == LAST_CELL) begin
					if (op_q == OP_PUT && ch_q != CH_NEWLINE) begin
						state_d = ST_PUTW;
					end else begin
						load    = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					sweep_d = sweep_q + AW'(1);
				end
			end
			ST_PUTW: begin
				// character that forced the scroll, now at the bottom row
				col_d     = col_q + CW'(1);
				mem_we    = 1'b1;
				mem_waddr = row_base + AW'(col_q);
				mem_wdata = char_cell;
				load      = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign pos_full          = 32'(line_d) * 32'(COLS) + 32'(col_d);
	assign res.cursor_pos    = pos_full[POS_W-1:0];
	assign res.cursor_line   = LINE_W'(line_d);
	assign res.cursor_column = COL_W'(col_d);
	assign res.read_char     = rd_hit ? mem_rdata[CHAR_W-1:0] : '0;
	assign res.read_attr     = rd_hit ? mem_rdata[CELL_W-1:CHAR_W] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			sweep_q    <= '0;
			line_q     <= LW'(1);
			col_q      <= '0;
			cp_pend_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			sweep_q    <= sweep_d;
			line_q     <= line_d;
			col_q      <= col_d;
			cp_pend_s1 <= cp_pend_d;
		end
	end

	always_ff @(posedge clk) begin
		cp_addr_s1 <= cp_addr_d;
		if (accept) begin
			op_q   <= operation;
			ch_q   <= char_code;
			attr_q <= attr;
			idx_q  <= cell_index;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/text_console_writer_unit.sv
// Item flow: taken in idle, run in the exec state once the result register is free,
// then its result is loaded into the result register; a read passes the read-wait state first.
// One item at a time: in_stall stays high until the sequencer is back in idle.
// A scroll adds a copy sweep moving rows up and a blank sweep of the bottom row.
// A clear item blanks the (ROWS-1)*COLS cells of rows 1 up, one cell written per cycle.
// Reset: cursor to line 1, column 0; a clearing pass blanks the store, in_stall high.
`default_nettype none

module text_console_writer_unit import tcw_pkg::*; #(
	parameter int COLS = COLS_DEF,
	parameter int ROWS = ROWS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// input transaction channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [OP_W-1:0]   operation,
	input  wire logic [CHAR_W-1:0] char_code,
	input  wire logic [ATTR_W-1:0] attr,
	input  wire logic [IDX_W-1:0]  cell_index,
	// result transaction channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [POS_W-1:0]       cursor_pos,
	output logic [LINE_W-1:0]      cursor_line,
	output logic [COL_W-1:0]       cursor_column,
	output logic [CHAR_W-1:0]      read_char,
	output logic [ATTR_W-1:0]      read_attr
);

	localparam int CELLS = ROWS * COLS;
	localparam int AW    = $clog2(CELLS);

	// sequencer <-> cell RAM
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [CELL_W-1:0] mem_rdata;

	// sequencer <-> result register
	logic        load;
	logic        out_free;
	tcw_result_t res_next;
	tcw_result_t res_held;

	// Cell store: character in the low byte, attribute in the high byte.
	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_cells (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Cursor state, item decode, and the copy/blank sweeps. One item at a time;
	// the next transaction is taken as soon as the result is handed off.
	tcw_seq #(
		.COLS (COLS),
		.ROWS (ROWS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.char_code  (char_code),
		.attr       (attr),
		.cell_index (cell_index),
		.out_free   (out_free),
		.load       (load),
		.res        (res_next),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	// Result register decouples the consumer: a finished result may wait here
	// while the sequencer already holds the next input transaction.
	tcw_outreg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.res_in    (res_next),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res_out   (res_held),
		.free      (out_free)
	);

	assign cursor_pos    = res_held.cursor_pos;
	assign cursor_line   = res_held.cursor_line;
	assign cursor_column = res_held.cursor_column;
	assign read_char     = res_held.read_char;
	assign read_attr     = res_held.read_attr;

endmodule

`default_nettype wire

FILE: rtl/tcw_checker.sv
// Port-level checker for the console writer, bound to the top level
`default_nettype none
`include "text_console_writer_unit_defines.svh"

module tcw_checker import tcw_pkg::*; #(
	parameter int COLS = COLS_DEF,
	parameter int ROWS = ROWS_DEF
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic [OP_W-1:0]   operation,
	input wire logic [CHAR_W-1:0] char_code,
	input wire logic [ATTR_W-1:0] attr,
	input wire logic [IDX_W-1:0]  cell_index,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [POS_W-1:0]  cursor_pos,
	input wire logic [LINE_W-1:0] cursor_line,
	input wire logic [COL_W-1:0]  cursor_column,
	input wire logic [CHAR_W-1:0] read_char,
	input wire logic [ATTR_W-1:0] read_attr
);

	// cursor fields are exact (not truncated) only for these sizes
	localparam bit FITS = (ROWS <= 32) && (COLS <= 127);

	logic [31:0] pos_calc;
	logic        unused_in;

	assign pos_calc  = 32'(cursor_line) * 32'(COLS) + 32'(cursor_column);
	assign unused_in = ^{operation, char_code, attr, cell_index};

	`TCWU_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(cursor_pos) && $stable(read_char) && $stable(read_attr))

	`TCWU_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall)

	`TCWU_ASSERT_IMPLIES(a_col_range, out_valid, 32'(cursor_column) <= 32'(COLS))

	`TCWU_ASSERT_IMPLIES(a_pos_match, out_valid && FITS && !unused_in || out_valid && FITS,
		cursor_pos == pos_calc[POS_W-1:0] && cursor_line != '0)

endmodule

bind text_console_writer_unit tcw_checker #(.COLS(COLS), .ROWS(ROWS)) u_tcw_checker (.*);

`default_nettype wire
